>>> rtl/core/tcc_pkg.sv
// shared types and constants of the text console cursor engine
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;

  // one result item as it waits in the output buffer
  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] cell_address;
    logic [CELL_W-1:0] cell_value;
    logic              clear_screen;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
  } result_t;

endpackage

>>> rtl/core/tcc_out_fifo.sv
// two-entry output buffer for result items
`timescale 1ns / 1ps

module tcc_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcc_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tcc_pkg::result_t data_o
);
  import tcc_pkg::*;

  result_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_ready_i && (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign data_o      = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/text_console_cursor_engine_core.sv
// top level of the text console cursor engine: cursor state, line length memory, output buffer
`timescale 1ns / 1ps

//  channel   | handshake                       | payload
//  ----------+---------------------------------+------------------------------------------
//  input     | in_valid_i / in_ready_o         | mode_i, char_code_i
//  result    | out_valid_o / out_ready_i       | write_enable_o, cell_address_o,
//            |                                 | cell_value_o, clear_screen_o,
//            |                                 | cursor_row_o, cursor_column_o
//  config    | text_attribute_we_i (no wait)   | text_attribute_i
//
//  one item per cycle while the buffer has room: the cursor update and the line length
//  memory write happen at the transfer edge, and the result enters a two-entry output buffer
//  the memory read port always holds the length of the row above the cursor, registered
//  with the next cursor row as address, so backspace at column zero needs no stall
//  in_ready_o drops only while both output buffer entries are waiting to be taken
//  reset clears cursor, attribute (to 0x0f), row valid bits and the buffer; the memory
//  itself is not cleared, rows without a valid bit read as length zero

module text_console_cursor_engine_core #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        text_attribute_we_i,
  input  logic [tcc_pkg::ATTR_W-1:0]  text_attribute_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [tcc_pkg::CHAR_W-1:0]  char_code_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        write_enable_o,
  output logic [tcc_pkg::ADDR_W-1:0]  cell_address_o,
  output logic [tcc_pkg::CELL_W-1:0]  cell_value_o,
  output logic                        clear_screen_o,
  output logic [tcc_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [tcc_pkg::COL_W-1:0]   cursor_column_o
);
  import tcc_pkg::*;

  localparam int IDX_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int FULL_W  = ROW_W + COL_W;

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_WIDTH = COL_W'(SCREEN_WIDTH);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_WIDTH - 1);

  // cursor and attribute
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ATTR_W-1:0] attr_q;

  // line length memory and per-row valid bits
  logic [COL_W-1:0]         len_mem [SCREEN_HEIGHT];
  logic [COL_W-1:0]         rd_data_q;
  logic [IDX_W-1:0]         rd_idx;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wr_idx;
  logic [COL_W-1:0]         mem_wr_data;
  logic [SCREEN_HEIGHT-1:0] valid_q, valid_d;

  // item decode
  logic             in_xfer;
  logic             is_bs, is_nl;
  logic [IDX_W-1:0] cur_idx, up_idx;
  logic [COL_W-1:0] col_inc, col_dec, addr_col, up_len;
  logic [ROW_W-1:0] row_down;
  logic [FULL_W-1:0] addr_full;
  logic             buf_full;
  result_t          res, res_out;

  assign in_ready_o = !buf_full;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign is_bs    = (char_code_i == CODE_BACKSPACE);
  assign is_nl    = (char_code_i == CODE_NEWLINE);
  assign cur_idx  = IDX_W'(row_q);
  assign up_idx   = IDX_W'(row_q - ROW_W'(1));
  assign col_inc  = col_q + COL_W'(1);
  assign col_dec  = col_q - COL_W'(1);
  assign row_down = (row_q < ROW_LAST) ? row_q + ROW_W'(1) : row_q;

  // length of the row above, zero if not written since it was entered or cleared
  assign up_len = valid_q[up_idx] ? rd_data_q : '0;

  // one constant multiply for the cell address, masked to the address width
  assign addr_col  = is_bs ? col_dec : col_q;
  assign addr_full = FULL_W'(row_q) * FULL_W'(SCREEN_WIDTH) + FULL_W'(addr_col);

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    valid_d     = valid_q;
    mem_we      = 1'b0;
    mem_wr_idx  = cur_idx;
    mem_wr_data = col_inc;

    res.write_enable = 1'b0;
    res.cell_address = '0;
    res.cell_value   = '0;
    res.clear_screen = 1'b0;

    if (in_xfer) begin
      if (mode_i) begin
        // clear: cursor home, every row length back to zero
        row_d            = '0;
        col_d            = '0;
        valid_d          = '0;
        res.cell_value   = {attr_q, CODE_SPACE};
        res.clear_screen = 1'b1;
      end else if (is_bs) begin
        if (col_q != '0) begin
          // blank the previous cell, the row now ends there
          col_d            = col_dec;
          mem_we           = 1'b1;
          mem_wr_data      = col_dec;
          valid_d[cur_idx] = 1'b1;
          res.write_enable = 1'b1;
          res.cell_address = addr_full[ADDR_W-1:0];
          res.cell_value   = {attr_q, CODE_SPACE};
        end else if (row_q != '0) begin
          // up to the end of the previous line, kept on screen
          row_d = row_q - ROW_W'(1);
          col_d = (up_len >= COL_WIDTH) ? COL_LAST : up_len;
        end
      end else if (is_nl) begin
        row_d                     = row_down;
        col_d                     = '0;
        valid_d[IDX_W'(row_down)] = 1'b0;
      end else begin
        // printable: write the cell, advance, wrap at the end of the line
        mem_we           = 1'b1;
        mem_wr_data      = col_inc;
        valid_d[cur_idx] = 1'b1;
        res.write_enable = 1'b1;
        res.cell_address = addr_full[ADDR_W-1:0];
        res.cell_value   = {attr_q, char_code_i};
        col_d            = col_inc;
        if (col_inc >= COL_WIDTH) begin
          row_d                     = row_down;
          col_d                     = '0;
          valid_d[IDX_W'(row_down)] = 1'b0;
        end
      end
    end

    res.cursor_row    = row_d;
    res.cursor_column = col_d;
  end

  // read one row above the next cursor row, ahead of any backspace
  assign rd_idx = (row_d == '0) ? '0 : IDX_W'(row_d - ROW_W'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      len_mem[mem_wr_idx] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    // forward a write to the same row in this cycle
    if (mem_we && (mem_wr_idx == rd_idx)) begin
      rd_data_q <= mem_wr_data;
    end else begin
      rd_data_q <= len_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= '0;
      attr_q  <= ATTR_RESET;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      valid_q <= valid_d;
      if (text_attribute_we_i) begin
        attr_q <= text_attribute_i;
      end
    end
  end

  tcc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign write_enable_o  = res_out.write_enable;
  assign cell_address_o  = res_out.cell_address;
  assign cell_value_o    = res_out.cell_value;
  assign clear_screen_o  = res_out.clear_screen;
  assign cursor_row_o    = res_out.cursor_row;
  assign cursor_column_o = res_out.cursor_column;

  // cursor never leaves the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COL_WIDTH) && (row_q <= ROW_LAST))
    else $error("cursor outside the screen");

  // a clear transfer homes the cursor and drops every row length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_i) |=> (row_q == '0) && (col_q == '0) && (valid_q == '0))
    else $error("clear did not reset cursor state");

  // newline lands on column zero with the new row's length invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !mode_i && is_nl) |=> (col_q == '0) && !valid_q[cur_idx])
    else $error("newline left stale cursor state");

  // a memory write always marks its row valid unless the cursor wrapped onto it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (row_d != row_q || col_d != '0)) |=> valid_q[$past(mem_wr_idx)])
    else $error("row length write lost its valid bit");

endmodule
